### hdl/frc_pkg.sv
// Shared types and constants for the flow rule classifier.
package frc_pkg;

  typedef enum logic [1:0] {
    MODE_RULE_HDR  = 2'd0,
    MODE_RULE_PORT = 2'd1,
    MODE_LOOKUP    = 2'd2
  } mode_e;

  localparam int unsigned PortW       = 16;
  localparam int unsigned GroupSize   = 8;
  localparam int unsigned GroupIdxW   = 3;
  localparam int unsigned RuleIdxOutW = 6;

  typedef struct packed {
    logic       proto_any;
    logic [7:0] protocol;
    logic       drop;
    logic [7:0] flag_mask;
    logic [3:0] port_count;
  } rule_hdr_t;

  typedef struct packed {
    logic [7:0]       proto;
    logic [PortW-1:0] dport;
    logic [7:0]       flags;
  } flow_key_t;

endpackage

### hdl/frc_rule_cell.sv
// One rule entry: header and port list storage plus its match logic.
module frc_rule_cell #(
  parameter int unsigned PORTS_PER_RULE = 8,
  parameter int unsigned PW = 3
) (
  input  logic                         clk_i,
  input  logic                         hdr_we_i,
  input  frc_pkg::rule_hdr_t           hdr_i,
  input  logic                         port_we_i,
  input  logic [PW-1:0]                port_slot_i,
  input  logic [frc_pkg::PortW-1:0]    port_value_i,
  input  frc_pkg::flow_key_t           key_i,
  output logic                         match_o,
  output logic                         drop_o
);
  import frc_pkg::*;

  rule_hdr_t        hdr_q;
  logic [PortW-1:0] ports_q [PORTS_PER_RULE];

  logic proto_ok;
  logic port_ok;
  logic flags_ok;

  always_ff @(posedge clk_i) begin
    if (hdr_we_i) begin
      hdr_q <= hdr_i;
    end
    if (port_we_i) begin
      ports_q[port_slot_i] <= port_value_i;
    end
  end

  always_comb begin
    proto_ok = hdr_q.proto_any || (hdr_q.protocol == key_i.proto);
    // A count of zero accepts any port; counts above the list size use the whole list.
    port_ok  = (hdr_q.port_count == 4'd0);
    for (int k = 0; k < int'(PORTS_PER_RULE); k++) begin
      if ((k < int'(hdr_q.port_count)) && (ports_q[k] == key_i.dport)) begin
        port_ok = 1'b1;
      end
    end
    flags_ok = ((key_i.flags & hdr_q.flag_mask) == hdr_q.flag_mask);
    match_o  = proto_ok && port_ok && flags_ok;
    drop_o   = hdr_q.drop;
  end

endmodule

### hdl/flow_rule_classifier_core.sv
// Flow rule classifier: rule table in parallel cells with a pipelined priority select.
// A lookup's result passes the key, match, group and output registers to reach the outputs.
// Throughput: one item per cycle; each stage holds its item only while the next one is full
// and stalled. Rule writes take effect at their accept edge and give no result.
// Reset clears the stage valid bits and active_rules; rule entries are undefined until written.
module flow_rule_classifier_core #(
  parameter int unsigned RULE_DEPTH     = 64,
  parameter int unsigned PORTS_PER_RULE = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [5:0]  rule_index_i,
  input  logic [2:0]  port_slot_i,
  input  logic        rule_proto_any_i,
  input  logic [7:0]  rule_protocol_i,
  input  logic        rule_drop_i,
  input  logic [7:0]  rule_flag_mask_i,
  input  logic [3:0]  rule_port_count_i,
  input  logic [15:0] rule_port_value_i,
  input  logic [7:0]  flow_proto_i,
  input  logic [15:0] flow_dport_i,
  input  logic [7:0]  flow_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        hit_o,
  output logic [5:0]  matched_rule_o,
  output logic        matched_drop_o
);
  import frc_pkg::*;

  localparam int unsigned IW   = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int unsigned PW   = (PORTS_PER_RULE > 1) ? $clog2(PORTS_PER_RULE) : 1;
  localparam int unsigned NG   = (RULE_DEPTH + GroupSize - 1) / GroupSize;
  localparam int unsigned PADW = NG * GroupSize;

  // Stage enables, from the output back to the input.
  logic en1, en2, en3, en4;
  logic in_accept;

  logic [6:0] active_rules_q;

  // Stage 1: lookup key.
  logic      s1_valid_q;
  flow_key_t s1_key_q;

  // Stage 2: per-rule match vectors.
  logic                  s2_valid_q;
  logic [RULE_DEPTH-1:0] cell_match;
  logic [RULE_DEPTH-1:0] cell_drop;
  logic [RULE_DEPTH-1:0] s2_drop_q;
  logic [RULE_DEPTH-1:0] s2_alert_q;

  // Stage 3: first hit within each group of rules.
  logic                 s3_valid_q;
  logic [PADW-1:0]      drop_pad;
  logic [PADW-1:0]      alert_pad;
  logic [NG-1:0]        g_drop_any_d, g_alert_any_d;
  logic [GroupIdxW-1:0] g_drop_sub_d [NG];
  logic [GroupIdxW-1:0] g_alert_sub_d [NG];
  logic [NG-1:0]        g_drop_any_q, g_alert_any_q;
  logic [GroupIdxW-1:0] g_drop_sub_q [NG];
  logic [GroupIdxW-1:0] g_alert_sub_q [NG];

  // Stage 4: output register.
  logic                 out_valid_q;
  logic                 hit_d, hit_q;
  logic                 drop_d, drop_q;
  logic [IW-1:0]        rule_d;
  logic [IW-1:0]        rule_q;
  logic                 drop_found, alert_found;
  logic [IW-1:0]        drop_idx, alert_idx;
  logic [IW+5:0]        rule_wide;

  // Table write decode.
  logic [IW+5:0]        ri_wide;
  logic [IW-1:0]        ri_idx;
  logic [PW+2:0]        slot_wide;
  logic [PW-1:0]        slot_idx;
  logic                 ri_in_range;
  logic                 slot_in_range;
  logic                 hdr_wr, port_wr, lookup_in;
  rule_hdr_t            hdr_in;

  assign en4 = !out_valid_q || !out_stall_i;
  assign en3 = !s3_valid_q || en4;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;

  assign in_stall_o = !en1;
  assign in_accept  = in_valid_i && en1;

  always_comb begin
    ri_wide       = {IW'(0), rule_index_i};
    ri_idx        = ri_wide[IW-1:0];
    slot_wide     = {PW'(0), port_slot_i};
    slot_idx      = slot_wide[PW-1:0];
    ri_in_range   = (int'(rule_index_i) < int'(RULE_DEPTH));
    slot_in_range = (int'(port_slot_i) < int'(PORTS_PER_RULE));
    hdr_wr        = 1'b0;
    port_wr       = 1'b0;
    lookup_in     = 1'b0;
    unique case (mode_e'(mode_i))
      MODE_RULE_HDR:  hdr_wr    = in_accept && ri_in_range;
      MODE_RULE_PORT: port_wr   = in_accept && ri_in_range && slot_in_range;
      MODE_LOOKUP:    lookup_in = in_accept;
      default: begin
      end
    endcase
    hdr_in.proto_any  = rule_proto_any_i;
    hdr_in.protocol   = rule_protocol_i;
    hdr_in.drop       = rule_drop_i;
    hdr_in.flag_mask  = rule_flag_mask_i;
    hdr_in.port_count = rule_port_count_i;
  end

  for (genvar r = 0; r < RULE_DEPTH; r++) begin : g_rule
    frc_rule_cell #(
      .PORTS_PER_RULE (PORTS_PER_RULE),
      .PW             (PW)
    ) u_cell (
      .clk_i        (clk_i),
      .hdr_we_i     (hdr_wr && (ri_idx == IW'(r))),
      .hdr_i        (hdr_in),
      .port_we_i    (port_wr && (ri_idx == IW'(r))),
      .port_slot_i  (slot_idx),
      .port_value_i (rule_port_value_i),
      .key_i        (s1_key_q),
      .match_o      (cell_match[r]),
      .drop_o       (cell_drop[r])
    );
  end

  // Valid bits and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_rules_q <= 7'd0;
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      s3_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        active_rules_q <= cfg_wdata_i;
      end
      if (en1) begin
        s1_valid_q <= lookup_in;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (en3) begin
        s3_valid_q <= s2_valid_q;
      end
      if (en4) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // Stage 2 match vectors, limited to the active rules.
  logic [RULE_DEPTH-1:0] drop_vec_d, alert_vec_d;

  always_comb begin
    for (int r = 0; r < int'(RULE_DEPTH); r++) begin
      drop_vec_d[r]  = cell_match[r] && cell_drop[r] && (r < int'(active_rules_q));
      alert_vec_d[r] = cell_match[r] && !cell_drop[r] && (r < int'(active_rules_q));
    end
  end

  // Stage 3: priority select inside each group.
  always_comb begin
    drop_pad  = PADW'(s2_drop_q);
    alert_pad = PADW'(s2_alert_q);
    for (int g = 0; g < int'(NG); g++) begin
      g_drop_any_d[g]  = 1'b0;
      g_alert_any_d[g] = 1'b0;
      g_drop_sub_d[g]  = '0;
      g_alert_sub_d[g] = '0;
      for (int s = int'(GroupSize) - 1; s >= 0; s--) begin
        if (drop_pad[g*GroupSize + s]) begin
          g_drop_any_d[g] = 1'b1;
          g_drop_sub_d[g] = GroupIdxW'(s);
        end
        if (alert_pad[g*GroupSize + s]) begin
          g_alert_any_d[g] = 1'b1;
          g_alert_sub_d[g] = GroupIdxW'(s);
        end
      end
    end
  end

  // Stage 4: first group with a hit; a drop rule wins over any alert rule.
  always_comb begin
    drop_found  = 1'b0;
    alert_found = 1'b0;
    drop_idx    = '0;
    alert_idx   = '0;
    for (int g = int'(NG) - 1; g >= 0; g--) begin
      if (g_drop_any_q[g]) begin
        drop_found = 1'b1;
        drop_idx   = IW'(g * int'(GroupSize) + int'(g_drop_sub_q[g]));
      end
      if (g_alert_any_q[g]) begin
        alert_found = 1'b1;
        alert_idx   = IW'(g * int'(GroupSize) + int'(g_alert_sub_q[g]));
      end
    end
    if (drop_found) begin
      hit_d  = 1'b1;
      drop_d = 1'b1;
      rule_d = drop_idx;
    end else if (alert_found) begin
      hit_d  = 1'b1;
      drop_d = 1'b0;
      rule_d = alert_idx;
    end else begin
      hit_d  = 1'b0;
      drop_d = 1'b0;
      rule_d = '0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_key_q.proto <= flow_proto_i;
      s1_key_q.dport <= flow_dport_i;
      s1_key_q.flags <= flow_flags_i;
    end
    if (en2) begin
      s2_drop_q  <= drop_vec_d;
      s2_alert_q <= alert_vec_d;
    end
    if (en3) begin
      g_drop_any_q  <= g_drop_any_d;
      g_alert_any_q <= g_alert_any_d;
      g_drop_sub_q  <= g_drop_sub_d;
      g_alert_sub_q <= g_alert_sub_d;
    end
    if (en4) begin
      hit_q  <= hit_d;
      drop_q <= drop_d;
      rule_q <= rule_d;
    end
  end

  assign rule_wide      = {6'd0, rule_q};
  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign matched_drop_o = drop_q;
  assign matched_rule_o = rule_wide[RuleIdxOutW-1:0];

endmodule
